// ===== hdl/rpc_pkg.sv =====
// ----------------------------------------------------------------------------
// Reflow profile controller package
// Shared widths, codes, reset values and step word field helpers.
// ----------------------------------------------------------------------------
package rpc_pkg;

   // Field widths
   localparam int STEP_WORD_W = 30;
   localparam int TARGET_W    = 12;
   localparam int HOLD_W      = 16;
   localparam int MODE_W      = 2;
   localparam int BAND_W      = 8;
   localparam int TEMP_W      = 12;
   localparam int CMD_W       = 2;
   localparam int PHASE_W     = 2;
   localparam int STEP_W      = 3;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 30;

   // Number of profile steps held in the configuration registers
   localparam int PROFILE_STEPS_DEFAULT = 4;
   localparam int PROFILE_STEPS_MAX     = 4;

   // Register index of the band register
   localparam logic [CSR_INDEX_W-1:0] CSR_BAND_INDEX = 3'd4;

   // Reset values of the step words and the band
   localparam logic [STEP_WORD_W-1:0] STEP_RESET [PROFILE_STEPS_MAX] = '{
      30'd480, 30'd246240, 30'd560, 30'd268517936
   };
   localparam logic [BAND_W-1:0] BAND_RESET = 8'd8;

   // Step modes; any code above hold means stop
   localparam logic [MODE_W-1:0] MODE_RISE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_HOLD = 2'd1;

   // Request commands
   typedef enum logic [CMD_W-1:0] {
      CMD_START  = 2'd0,
      CMD_SAMPLE = 2'd1,
      CMD_TICK   = 2'd2
   } cmd_type;

   // Run phase
   typedef enum logic [PHASE_W-1:0] {
      PHASE_IDLE = 2'd0,
      PHASE_RUN  = 2'd1,
      PHASE_DONE = 2'd2
   } phase_type;

   // Step word field extraction
   function automatic logic [TARGET_W-1:0] target_of(input logic [STEP_WORD_W-1:0] word);
      return word[11:0];
   endfunction

   function automatic logic [HOLD_W-1:0] hold_of(input logic [STEP_WORD_W-1:0] word);
      return word[27:12];
   endfunction

   function automatic logic [MODE_W-1:0] mode_of(input logic [STEP_WORD_W-1:0] word);
      return word[29:28];
   endfunction

endpackage

// ===== hdl/rpc_if.sv =====
// ----------------------------------------------------------------------------
// Reflow profile controller channel interfaces
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------

// Request channel: command and temperature sample
interface rpc_req_if;
   logic                           valid;
   logic                           ready;
   logic [rpc_pkg::CMD_W-1:0]      command;
   logic [rpc_pkg::TEMP_W-1:0]     temperature;

   modport source (output valid, command, temperature, input ready);
   modport sink   (input valid, command, temperature, output ready);
endinterface

// Response channel: heater drive and run status
interface rpc_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           heater_on;
   logic [rpc_pkg::PHASE_W-1:0]    phase;
   logic [rpc_pkg::STEP_W-1:0]     step_index;
   logic [rpc_pkg::HOLD_W-1:0]     remaining_seconds;

   modport source (output valid, heater_on, phase, step_index, remaining_seconds,
                   input ready);
   modport sink   (input valid, heater_on, phase, step_index, remaining_seconds,
                   output ready);
endinterface

// ===== hdl/reflow_profile_controller.sv =====
// Response: registered; it appears in the cycle after its request transaction is accepted.
// Throughput: one transaction per cycle; the request side stays ready while the
// response register is empty or being drained in the same cycle.
// Reset: synchronous and active high; the run returns to idle at step 0 with the
// heater off, and the step words and band return to their default profile.
// ----------------------------------------------------------------------------
// Reflow profile controller
// Sequences an oven heater through a configurable multi-step temperature profile.
// ----------------------------------------------------------------------------
module reflow_profile_controller #(
   parameter int PROFILE_STEPS = rpc_pkg::PROFILE_STEPS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [rpc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [rpc_pkg::CSR_DATA_W-1:0]   csr_wr_data,
   rpc_req_if.sink                          req_chan,
   rpc_rsp_if.source                        rsp_chan
);

   logic [PROFILE_STEPS-1:0][rpc_pkg::STEP_WORD_W-1:0] step_words;
   logic [rpc_pkg::BAND_W-1:0]                         band;

   // Configuration registers
   rpc_csr #(
      .PROFILE_STEPS (PROFILE_STEPS)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .step_words  (step_words),
      .band        (band)
   );

   // Profile sequencing and heater control
   rpc_core #(
      .PROFILE_STEPS (PROFILE_STEPS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .step_words (step_words),
      .band       (band),
      .req        (req_chan),
      .rsp        (rsp_chan)
   );

endmodule

// ===== hdl/rpc_csr.sv =====
// ----------------------------------------------------------------------------
// Reflow profile controller configuration registers
// Holds the profile step words and the hysteresis band.
// ----------------------------------------------------------------------------
module rpc_csr #(
   parameter int PROFILE_STEPS = rpc_pkg::PROFILE_STEPS_DEFAULT
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           csr_wr_en,
   input  logic [rpc_pkg::CSR_INDEX_W-1:0]                csr_index,
   input  logic [rpc_pkg::CSR_DATA_W-1:0]                 csr_wr_data,
   output logic [PROFILE_STEPS-1:0][rpc_pkg::STEP_WORD_W-1:0] step_words,
   output logic [rpc_pkg::BAND_W-1:0]                     band
);

   logic [PROFILE_STEPS-1:0][rpc_pkg::STEP_WORD_W-1:0] words_ff;
   logic [rpc_pkg::BAND_W-1:0]                         band_ff;

   // Step word registers, one per profile step
   always_ff @(posedge clock) begin
      for (int i = 0; i < PROFILE_STEPS; i++) begin
         if (reset) begin
            words_ff[i] <= rpc_pkg::STEP_RESET[i];
         end else if (csr_wr_en && csr_index == rpc_pkg::CSR_INDEX_W'(i)) begin
            words_ff[i] <= csr_wr_data[rpc_pkg::STEP_WORD_W-1:0];
         end
      end
   end

   // Band register
   always_ff @(posedge clock) begin
      if (reset) begin
         band_ff <= rpc_pkg::BAND_RESET;
      end else if (csr_wr_en && csr_index == rpc_pkg::CSR_BAND_INDEX) begin
         band_ff <= csr_wr_data[rpc_pkg::BAND_W-1:0];
      end
   end

   assign step_words = words_ff;
   assign band       = band_ff;

endmodule

// ===== hdl/rpc_core.sv =====
// ----------------------------------------------------------------------------
// Reflow profile controller core
// Run state, band control, step sequencing and the response register.
// ----------------------------------------------------------------------------
module rpc_core #(
   parameter int PROFILE_STEPS = rpc_pkg::PROFILE_STEPS_DEFAULT
) (
   input  logic                                               clock,
   input  logic                                               reset,
   input  logic [PROFILE_STEPS-1:0][rpc_pkg::STEP_WORD_W-1:0] step_words,
   input  logic [rpc_pkg::BAND_W-1:0]                         band,
   rpc_req_if.sink                                            req,
   rpc_rsp_if.source                                          rsp
);

   localparam logic [rpc_pkg::STEP_W-1:0] STEP_END = rpc_pkg::STEP_W'(PROFILE_STEPS);
   localparam logic [rpc_pkg::HOLD_W-1:0] HOLD_MAX = '1;

   // State and response registers
   rpc_pkg::phase_type              phase_ff, phase_in;
   logic [rpc_pkg::STEP_W-1:0]      step_ff, step_in;
   logic                            heater_ff, heater_in;
   logic [rpc_pkg::HOLD_W-1:0]      elapsed_ff, elapsed_in;
   logic [rpc_pkg::HOLD_W-1:0]      remaining_ff, remaining_in;
   logic                            rsp_valid_ff, rsp_valid_in;

   logic                            accept;
   logic [rpc_pkg::STEP_WORD_W-1:0] cur_word;
   logic [rpc_pkg::STEP_WORD_W-1:0] nxt_word;
   logic [rpc_pkg::MODE_W-1:0]      cur_mode;
   logic [rpc_pkg::TARGET_W-1:0]    cur_target;
   logic [rpc_pkg::HOLD_W-1:0]      elapsed_inc;
   logic                            temp_above;
   logic                            temp_below;

   // Step entry search results
   logic [rpc_pkg::STEP_W-1:0]      ent_base;
   logic                            ent_found;
   logic [rpc_pkg::STEP_W-1:0]      ent_step;
   logic                            ent_fin;

   // A new transaction is taken whenever the response register is free or drains
   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;

   // Select the current step word
   always_comb begin
      cur_word = '0;
      for (int i = 0; i < PROFILE_STEPS; i++) begin
         if (step_ff == rpc_pkg::STEP_W'(i)) begin
            cur_word = step_words[i];
         end
      end
   end

   // Select the word of the step after this transaction
   always_comb begin
      nxt_word = '0;
      for (int i = 0; i < PROFILE_STEPS; i++) begin
         if (step_in == rpc_pkg::STEP_W'(i)) begin
            nxt_word = step_words[i];
         end
      end
   end

   assign cur_mode    = rpc_pkg::mode_of(cur_word);
   assign cur_target  = rpc_pkg::target_of(cur_word);
   assign elapsed_inc = (elapsed_ff != HOLD_MAX) ? elapsed_ff + 1'b1 : elapsed_ff;

   // Band comparisons, widened by one bit so the sums cannot wrap
   assign temp_above = {1'b0, req.temperature} >
                       ({1'b0, cur_target} + {5'b0, band});
   assign temp_below = ({1'b0, req.temperature} + {5'b0, band}) <
                       {1'b0, cur_target};

   // Find the first step at or after the base that is not a zero-length hold
   always_comb begin
      ent_base  = (req.command == rpc_pkg::CMD_START) ? '0 : step_ff + 1'b1;
      ent_found = 1'b0;
      ent_step  = STEP_END;
      ent_fin   = 1'b1;
      for (int i = 0; i < PROFILE_STEPS; i++) begin
         if (!ent_found && rpc_pkg::STEP_W'(i) >= ent_base) begin
            if (rpc_pkg::mode_of(step_words[i]) > rpc_pkg::MODE_HOLD) begin
               ent_found = 1'b1;
               ent_step  = rpc_pkg::STEP_W'(i);
               ent_fin   = 1'b1;
            end else if (!(rpc_pkg::mode_of(step_words[i]) == rpc_pkg::MODE_HOLD &&
                           rpc_pkg::hold_of(step_words[i]) == '0)) begin
               ent_found = 1'b1;
               ent_step  = rpc_pkg::STEP_W'(i);
               ent_fin   = 1'b0;
            end
         end
      end
   end

   // Next run state for the transaction at the request port
   always_comb begin
      logic do_enter;
      logic do_finish;
      logic [rpc_pkg::STEP_W-1:0] fin_step;

      phase_in   = phase_ff;
      step_in    = step_ff;
      heater_in  = heater_ff;
      elapsed_in = elapsed_ff;
      do_enter   = 1'b0;
      do_finish  = 1'b0;
      fin_step   = step_ff;

      case (req.command)
         rpc_pkg::CMD_START: begin
            phase_in  = rpc_pkg::PHASE_RUN;
            heater_in = 1'b0;
            do_enter  = 1'b1;
         end
         rpc_pkg::CMD_SAMPLE, rpc_pkg::CMD_TICK: begin
            if (phase_ff == rpc_pkg::PHASE_RUN) begin
               if (step_ff >= STEP_END) begin
                  do_finish = 1'b1;
                  fin_step  = STEP_END;
               end else if (cur_mode > rpc_pkg::MODE_HOLD) begin
                  do_finish = 1'b1;
               end else if (req.command == rpc_pkg::CMD_SAMPLE) begin
                  if (temp_above) begin
                     heater_in = 1'b0;
                  end
                  if (temp_below) begin
                     heater_in = 1'b1;
                  end
                  if (cur_mode == rpc_pkg::MODE_RISE && req.temperature >= cur_target) begin
                     do_enter = 1'b1;
                  end
               end else if (cur_mode == rpc_pkg::MODE_HOLD) begin
                  elapsed_in = elapsed_inc;
                  if (elapsed_inc >= rpc_pkg::hold_of(cur_word)) begin
                     do_enter = 1'b1;
                  end
               end
            end
         end
         default: begin
         end
      endcase

      // Entering a step may end the run when it lands on a stop or past the end
      if (do_enter) begin
         elapsed_in = '0;
         step_in    = ent_step;
         if (ent_fin) begin
            do_finish = 1'b1;
            fin_step  = ent_step;
         end
      end

      if (do_finish) begin
         phase_in   = rpc_pkg::PHASE_DONE;
         heater_in  = 1'b0;
         step_in    = fin_step;
         elapsed_in = '0;
      end
   end

   // Seconds left in a running hold step after this transaction
   always_comb begin
      remaining_in = '0;
      if (phase_in == rpc_pkg::PHASE_RUN && step_in < STEP_END &&
          rpc_pkg::mode_of(nxt_word) == rpc_pkg::MODE_HOLD &&
          rpc_pkg::hold_of(nxt_word) > elapsed_in) begin
         remaining_in = rpc_pkg::hold_of(nxt_word) - elapsed_in;
      end
   end

   // Response valid follows accepted transactions and drains on ready
   assign rsp_valid_in = accept ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= rpc_pkg::PHASE_IDLE;
         step_ff      <= '0;
         heater_ff    <= 1'b0;
         elapsed_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            phase_ff   <= phase_in;
            step_ff    <= step_in;
            heater_ff  <= heater_in;
            elapsed_ff <= elapsed_in;
         end
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         remaining_ff <= remaining_in;
      end
   end

   // The state registers hold the post-transaction status, so they drive the payload
   assign rsp.valid             = rsp_valid_ff;
   assign rsp.heater_on         = heater_ff;
   assign rsp.phase             = phase_ff;
   assign rsp.step_index        = step_ff;
   assign rsp.remaining_seconds = remaining_ff;

endmodule
